>>> src/u16nl_pkg.sv
package u16nl_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    // line ending conventions
    localparam logic [1:0] FMT_WIN  = 2'd0;
    localparam logic [1:0] FMT_UNIX = 2'd1;
    localparam logic [1:0] FMT_MAC  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SOURCE = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_SWAP   = 2'd2;

    // byte position of the character in a newline unit
    localparam logic POS_FIRST  = 1'b0;
    localparam logic POS_SECOND = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } unit_t;

    typedef struct packed {
        logic [7:0] out_first_byte;
        logic [7:0] out_second_byte;
        logic       run_end;
    } result_t;

    typedef struct packed {
        logic [1:0] source_format;
        logic [1:0] target_format;
        logic       swap_enable;
    } cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic       newline;
        logic       pos;
    } op_t;

endpackage

>>> src/u16nl_front.sv
module u16nl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  u16nl_pkg::cfg_t cfg,
    input  u16nl_pkg::unit_t unit,
    input  logic            accept,
    output logic            op_push,
    output u16nl_pkg::op_t  op
);
    import u16nl_pkg::*;

    logic pos_reg, pos_next;
    logic pend_reg, pend_next;
    logic hit_cr, hit_lf;
    logic newline, drop;

    always_comb
    begin
        hit_cr    = (unit.first_byte == CH_CR) || (unit.second_byte == CH_CR);
        hit_lf    = (unit.first_byte == CH_LF) || (unit.second_byte == CH_LF);
        newline   = 1'b0;
        drop      = 1'b0;
        pend_next = 1'b0;
        if (cfg.source_format == FMT_WIN)
        begin
            if (pend_reg)
                newline = 1'b1;
            else if (hit_cr)
            begin
                drop      = 1'b1;
                pend_next = 1'b1;
            end
        end
        else if (cfg.source_format == FMT_UNIX)
            newline = hit_lf;
        else if (cfg.source_format == FMT_MAC)
            newline = hit_cr;

        pos_next = pos_reg;
        if (newline)
        begin
            if (unit.first_byte == CH_NUL)
                pos_next = POS_SECOND;
            else if (unit.second_byte == CH_NUL)
                pos_next = POS_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_SECOND;
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    assign op_push    = accept && !drop;
    assign op.b0      = unit.first_byte;
    assign op.b1      = unit.second_byte;
    assign op.newline = newline;
    assign op.pos     = pos_next;

endmodule

>>> src/u16nl_queue.sv
module u16nl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  u16nl_pkg::op_t wr_data,
    input  logic           rd,
    output u16nl_pkg::op_t rd_data,
    output logic           q_full,
    output logic           q_empty
);
    import u16nl_pkg::*;

    op_t            mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            if (wr && !rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd && !wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign rd_data = mem[rp_reg];
    assign q_full  = (cnt_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);

endmodule

>>> src/u16nl_back.sv
module u16nl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u16nl_pkg::cfg_t   cfg,
    input  u16nl_pkg::op_t    op,
    input  logic              op_empty,
    output logic              op_pop,
    input  logic              pop,
    output logic              empty,
    output u16nl_pkg::result_t result
);
    import u16nl_pkg::*;

    logic    valid_reg;
    logic    phase_reg, phase_next;
    result_t res_reg, res_next;
    logic    load;
    logic    two;
    logic [7:0] u0, u1, nl_byte;
    logic    last;

    assign load = !op_empty && (!valid_reg || pop);
    assign two  = op.newline && (cfg.target_format == FMT_WIN);

    always_comb
    begin
        nl_byte = (cfg.target_format == FMT_MAC) ? CH_CR : CH_LF;
        u0      = op.b0;
        u1      = op.b1;
        last    = 1'b1;
        if (two)
        begin
            if (!phase_reg)
            begin
                last = 1'b0;
                if (op.pos == POS_FIRST) u0 = CH_CR;
                else                     u1 = CH_CR;
            end
            else if (op.pos == POS_FIRST)
            begin
                u0 = CH_LF;
                u1 = CH_NUL;
            end
            else
            begin
                u0 = CH_NUL;
                u1 = CH_LF;
            end
        end
        else if (op.newline)
        begin
            if (op.pos == POS_FIRST) u0 = nl_byte;
            else                     u1 = nl_byte;
        end
        res_next.out_first_byte  = cfg.swap_enable ? u1 : u0;
        res_next.out_second_byte = cfg.swap_enable ? u0 : u1;
        res_next.run_end         = last;
        phase_next = two && !phase_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= phase_next;
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

    assign op_pop = load && !phase_next;
    assign empty  = !valid_reg;
    assign result = res_reg;

endmodule

>>> src/utf16_newline_converter_core.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// unit     | push in / full out    | first_byte, second_byte
// result   | empty out / pop in    | out_first_byte, out_second_byte, run_end
// config   | cfg_write in          | cfg_index (0 source, 1 target, 2 swap), cfg_data
//
// One item per cycle in while full is low, one result per cycle out while pop
// is held. An accepted item passes through the op queue and the output
// register to the result port. A newline with a win target yields two results
// and holds the back end until both are issued; the 4-entry op queue absorbs
// isolated ones, while a dense run of them, or pop held low, fills the queue
// and full stalls input. A swallowed CR takes no queue entry and yields no
// result. Reset clears queue, output valid flag, line state and config to defaults.
module utf16_newline_converter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  u16nl_pkg::unit_t   unit,
    output logic               empty,
    input  logic               pop,
    output u16nl_pkg::result_t result,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data
);
    import u16nl_pkg::*;

    cfg_t cfg_reg;
    op_t  front_op, head_op;
    logic accept;
    logic op_push, op_pop;
    logic q_full, q_empty;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= FMT_UNIX;
            cfg_reg.target_format <= FMT_UNIX;
            cfg_reg.swap_enable   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE: cfg_reg.source_format <= cfg_data;
                REG_TARGET: cfg_reg.target_format <= cfg_data;
                REG_SWAP:   cfg_reg.swap_enable   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // input is held off only while the op queue is full
    assign full   = q_full;
    assign accept = push && !q_full;

    u16nl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .unit    (unit),
        .accept  (accept),
        .op_push (op_push),
        .op      (front_op)
    );

    u16nl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (op_push),
        .wr_data (front_op),
        .rd      (op_pop),
        .rd_data (head_op),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    u16nl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .op       (head_op),
        .op_empty (q_empty),
        .op_pop   (op_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
